/* design/rcprd_pkg.sv */
// Shared types and constants of the radio-control packet receiver and decoder.
`timescale 1ns / 1ps

package rcprd_pkg;

  localparam int unsigned StepW    = 16;
  localparam int unsigned ElapsedW = 25;
  localparam int unsigned LimitW   = 24;
  localparam int unsigned TableW   = 32;
  localparam int unsigned AddrW    = 24;
  localparam int unsigned StickW   = 9;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 80;
  localparam int unsigned OutUserW = 3;

  // Queue between the classifying front and the executing back.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0]          BindChannel  = 8'h4D;
  localparam logic [7:0]          StickCenter  = 8'd50;
  localparam logic [TableW-1:0]   HopTableRst  = 32'h0727_434D;
  localparam logic [LimitW-1:0]   FailLimitRst = 24'd1000000;
  localparam logic [AddrW-1:0]    AddrRst      = 24'hE7E7E7;
  localparam logic [ElapsedW-1:0] ElapsedMax   = '1;

  // Bit positions of the mode flags inside payload byte 5.
  localparam int unsigned FlagExpertBit   = 0;
  localparam int unsigned FlagHeadlessBit = 2;
  localparam int unsigned FlagReturnBit   = 6;
  localparam int unsigned FlagFlipBit     = 7;

  typedef enum logic [2:0] {
    StNone     = 3'd0,
    StBindOk   = 3'd1,
    StBindFail = 3'd2,
    StDataOk   = 3'd3,
    StDataFail = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHopTable  = 2'd0,
    CfgFailLimit = 2'd1
  } cfg_idx_e;

  // One classified word as it travels from the front to the back.
  typedef struct packed {
    logic             has_payload;
    logic             bind_sum_ok;
    logic             data_sum_ok;
    logic [StepW-1:0] step;
    logic [7:0]       b6;
    logic [7:0]       b5;
    logic [7:0]       b4;
    logic [7:0]       b3;
    logic [7:0]       b2;
    logic [7:0]       b1;
    logic [7:0]       b0;
  } cmd_t;

  localparam int unsigned CmdW = $bits(cmd_t);

  // One result word.
  typedef struct packed {
    status_e                  status;
    logic                     failsafe_active;
    logic signed [StickW-1:0] aileron;
    logic signed [StickW-1:0] elevator;
    logic signed [StickW-1:0] rudder;
    logic [7:0]               throttle;
    logic [3:0]               mode_flags;
    logic [3:0]               flags_changed;
    logic [7:0]               radio_channel;
    logic [AddrW-1:0]         bound_address;
    logic                     is_bound;
  } result_t;

  typedef struct packed {
    logic                valid;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

endpackage

/* design/rcprd_front.sv */
// Front stage: takes input words, checks both checksums and registers the command.
`timescale 1ns / 1ps

module rcprd_front
  import rcprd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [InDataW-1:0] in_data_i,
  input  logic               in_func_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output cmd_t               cmd_o
);

  logic       valid_q, valid_d;
  cmd_t       cmd_q, cmd_d;
  logic [7:0] byte_w [8];
  logic [7:0] bind_sum;
  logic [7:0] data_sum;
  logic       accept;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      byte_w[i] = in_data_i[StepW + 8*i +: 8];
    end
  end

  // Both sums are formed here; the back picks the one that fits its mode.
  assign bind_sum = byte_w[4] + byte_w[5] + byte_w[6];
  assign data_sum = byte_w[0] + byte_w[1] + byte_w[2] + byte_w[3] + bind_sum;

  assign in_ready_o = !valid_q || cmd_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_d             = cmd_q;
    cmd_d.has_payload = in_func_i;
    cmd_d.bind_sum_ok = (bind_sum == byte_w[7]);
    cmd_d.data_sum_ok = (data_sum == byte_w[7]);
    cmd_d.step        = in_data_i[StepW-1:0];
    cmd_d.b0          = byte_w[0];
    cmd_d.b1          = byte_w[1];
    cmd_d.b2          = byte_w[2];
    cmd_d.b3          = byte_w[3];
    cmd_d.b4          = byte_w[4];
    cmd_d.b5          = byte_w[5];
    cmd_d.b6          = byte_w[6];
    if (accept) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

/* design/rcprd_queue.sv */
// Short command queue that decouples the front from the back.
`timescale 1ns / 1ps

module rcprd_queue
  import rcprd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  cmd_t             entry_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != QCntW'(QDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

/* design/rcprd_back.sv */
// Back stage: link state, failsafe timer, configuration registers and result register.
`timescale 1ns / 1ps

module rcprd_back
  import rcprd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_wr_t cfg_i,
  input  logic    cmd_valid_i,
  output logic    cmd_ready_o,
  input  cmd_t    cmd_i,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  logic [TableW-1:0]        hop_table_q;
  logic [LimitW-1:0]        fail_limit_q;
  logic                     normal_q, normal_d;
  logic [AddrW-1:0]         addr_q, addr_d;
  logic [1:0]               hop_q, hop_d;
  logic signed [StickW-1:0] ail_q, ail_d, ele_q, ele_d, rud_q, rud_d;
  logic [7:0]               thr_q, thr_d;
  logic [3:0]               flag_q, flag_d, chg_q, chg_d;
  logic [ElapsedW-1:0]      elapsed_q, elapsed_d;
  logic                     fs_q, fs_d;
  logic                     res_valid_q;
  result_t                  res_q, res_d;
  logic [ElapsedW:0]        elapsed_sum;
  logic [3:0]               new_flags;
  status_e                  status;
  logic                     take;

  // A command executes whenever the result register is free or being emptied.
  assign cmd_ready_o = !res_valid_q || res_ready_i;
  assign take        = cmd_valid_i && cmd_ready_o;

  assign elapsed_sum = {1'b0, elapsed_q} + (ElapsedW + 1)'(cmd_i.step);
  assign new_flags   = {cmd_i.b5[FlagFlipBit], cmd_i.b5[FlagReturnBit],
                        cmd_i.b5[FlagHeadlessBit], cmd_i.b5[FlagExpertBit]};

  always_comb begin
    normal_d  = normal_q;
    addr_d    = addr_q;
    hop_d     = hop_q;
    ail_d     = ail_q;
    ele_d     = ele_q;
    rud_d     = rud_q;
    thr_d     = thr_q;
    flag_d    = flag_q;
    chg_d     = chg_q;
    fs_d      = fs_q;
    status    = StNone;
    elapsed_d = elapsed_sum[ElapsedW] ? ElapsedMax : elapsed_sum[ElapsedW-1:0];

    if (cmd_i.has_payload) begin
      if (!normal_q) begin
        if (cmd_i.bind_sum_ok) begin
          addr_d   = {cmd_i.b6, cmd_i.b5, cmd_i.b4};
          normal_d = 1'b1;
          status   = StBindOk;
        end else begin
          status = StBindFail;
        end
      end else begin
        if (cmd_i.data_sum_ok) begin
          ail_d     = {1'b0, cmd_i.b3} - {1'b0, StickCenter};
          ele_d     = {1'b0, cmd_i.b2} - {1'b0, StickCenter};
          rud_d     = {1'b0, cmd_i.b1} - {1'b0, StickCenter};
          thr_d     = cmd_i.b0;
          chg_d     = flag_q ^ new_flags;
          flag_d    = new_flags;
          elapsed_d = '0;
          fs_d      = 1'b0;
          status    = StDataOk;
        end else begin
          status = StDataFail;
        end
        hop_d = hop_q + 1'b1;
      end
    end

    if (elapsed_d > {1'b0, fail_limit_q}) begin
      fs_d  = 1'b1;
      ail_d = '0;
      ele_d = '0;
      rud_d = '0;
      thr_d = '0;
    end

    res_d.status          = status;
    res_d.failsafe_active = fs_d;
    res_d.aileron         = ail_d;
    res_d.elevator        = ele_d;
    res_d.rudder          = rud_d;
    res_d.throttle        = thr_d;
    res_d.mode_flags      = flag_d;
    res_d.flags_changed   = chg_d;
    res_d.radio_channel   = normal_d ? hop_table_q[8*hop_d +: 8] : BindChannel;
    res_d.bound_address   = addr_d;
    res_d.is_bound        = normal_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hop_table_q  <= HopTableRst;
      fail_limit_q <= FailLimitRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgHopTable:  hop_table_q  <= cfg_i.data;
        CfgFailLimit: fail_limit_q <= cfg_i.data[LimitW-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_q    <= 1'b0;
      addr_q      <= AddrRst;
      hop_q       <= '0;
      ail_q       <= '0;
      ele_q       <= '0;
      rud_q       <= '0;
      thr_q       <= '0;
      flag_q      <= '0;
      chg_q       <= '0;
      elapsed_q   <= '0;
      fs_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (take) begin
        normal_q  <= normal_d;
        addr_q    <= addr_d;
        hop_q     <= hop_d;
        ail_q     <= ail_d;
        ele_q     <= ele_d;
        rud_q     <= rud_d;
        thr_q     <= thr_d;
        flag_q    <= flag_d;
        chg_q     <= chg_d;
        elapsed_q <= elapsed_d;
        fs_q      <= fs_d;
      end
      if (take) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // While failsafe holds, every stick reads zero.
  a_failsafe_sticks_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fs_q |-> (ail_q == '0 && ele_q == '0 && rud_q == '0 && thr_q == '0))
    else $error("sticks not zero while failsafe is active");

  // Before binding the radio stays on the bind channel.
  a_unbound_bind_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.is_bound) |-> (res_q.radio_channel == BindChannel))
    else $error("unbound result off the bind channel");

  // Data packets are only reported once bound.
  a_data_needs_bind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (res_q.status == StDataOk || res_q.status == StDataFail))
    |-> res_q.is_bound)
    else $error("data status reported while in bind mode");

  // A successful data packet leaves failsafe and restarts the timer.
  a_data_ok_clears_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && status == StDataOk) |=> (elapsed_q == '0))
    else $error("timer not cleared by a valid data packet");

endmodule

/* design/rc_packet_receiver_decoder.sv */
// Top level of the radio-control packet receiver and decoder.
`timescale 1ns / 1ps

// Receiver side of a radio-control link. Each input word carries the microseconds
// elapsed since the previous word and, when tuser is set, an 8-byte payload. After
// reset the block is in bind mode on channel 0x4D: a payload whose 8-bit sum of
// bytes 4 to 6 equals byte 7 teaches the 24-bit address and moves the block to
// normal mode. In normal mode an 8-bit sum over bytes 0 to 6 must equal byte 7;
// a good packet updates the held sticks and mode flags, records which flags
// changed, clears the failsafe timer and leaves failsafe. Every normal-mode packet,
// good or bad, steps through the four hop channels of the channel table. When the
// timer runs past the failsafe limit, failsafe is set and the sticks read zero.
// Every input word yields exactly one result word. The block sustains one word per
// clock cycle in both directions while the result side does not stall; the back
// stage does its whole timer update (add, saturate, compare against the limit)
// as each command executes, which is what allows that rate. An accepted word is
// registered in the front register, then written into the command queue and then
// into the result register, from which its result is offered. The two-entry queue
// lets the front keep taking words while the result side is stalled, until the
// queue is full. Configuration writes are always accepted and belong in idle
// periods; index 0 is the hop channel table, index 1 the failsafe limit, other
// indexes are ignored.
module rc_packet_receiver_decoder
  import rcprd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input stream.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // time_step_us[15:0], byte0[23:16], byte1 .. byte7 up to [79:72]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // func[0]
  input  logic                s_axis_tuser,
  // Result stream.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // failsafe_active[0], aileron[9:1], elevator[18:10], rudder[27:19],
  // throttle[35:28], mode_flags[39:36], flags_changed[43:40],
  // radio_channel[51:44], bound_address[75:52], is_bound[76], zero[79:77]
  output logic [OutDataW-1:0] m_axis_tdata,
  // status[2:0]
  output logic [OutUserW-1:0] m_axis_tuser,
  // Configuration write channel.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic    fr_valid, fr_ready;
  cmd_t    fr_cmd;
  logic    q_valid, q_ready;
  cmd_t    q_cmd;
  cfg_wr_t cfg_wr;
  result_t res;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  rcprd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_func_i   (s_axis_tuser),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_o       (fr_cmd)
  );

  rcprd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_cmd_i   (fr_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_cmd_o    (q_cmd)
  );

  rcprd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_wr),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tuser = res.status;
  assign m_axis_tdata = {3'b000, res.is_bound, res.bound_address, res.radio_channel,
                         res.flags_changed, res.mode_flags, res.throttle,
                         res.rudder, res.elevator, res.aileron, res.failsafe_active};

endmodule

/* tb/rcprd_checker.sv */
// Checker that predicts and compares the result words of the radio-control packet receiver.
`timescale 1ns / 1ps

module rcprd_checker
  import rcprd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic [OutUserW-1:0] m_axis_tuser,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         mismatches_o,
  output int unsigned         pending_o
);

  // Predicted copy of the register file.
  logic [TableW-1:0]   hop_table;
  logic [LimitW-1:0]   fail_limit;

  // Predicted receiver state.
  logic                bound;
  logic [AddrW-1:0]    addr;
  logic [1:0]          hop;
  logic [StickW-1:0]   aileron_hold;
  logic [StickW-1:0]   elevator_hold;
  logic [StickW-1:0]   rudder_hold;
  logic [7:0]          throttle_hold;
  logic [3:0]          flag_hold;
  logic [3:0]          change_hold;
  logic [ElapsedW-1:0] elapsed;
  logic                failsafe;

  result_t             awaited_words[$];
  int unsigned         errors;

  // Applies one input word to the predicted state and returns the result word it yields.
  function automatic result_t decode_word(input logic func, input logic [StepW-1:0] step,
                                          input logic [63:0] payload);
    logic [7:0]        b [8];
    logic [7:0]        sum;
    logic [3:0]        new_flags;
    logic [ElapsedW:0] grown;
    result_t           r;
    for (int i = 0; i < 8; i++) b[i] = payload[8*i +: 8];
    r.status = StNone;
    grown = {1'b0, elapsed} + (ElapsedW + 1)'(step);
    elapsed = (grown > {1'b0, ElapsedMax}) ? ElapsedMax : grown[ElapsedW-1:0];
    if (func) begin
      if (!bound) begin
        sum = b[4] + b[5] + b[6];
        if (sum == b[7]) begin
          addr = {b[6], b[5], b[4]};
          bound = 1'b1;
          r.status = StBindOk;
        end else begin
          r.status = StBindFail;
        end
      end else begin
        sum = b[0] + b[1] + b[2] + b[3] + b[4] + b[5] + b[6];
        if (sum == b[7]) begin
          aileron_hold  = {1'b0, b[3]} - {1'b0, StickCenter};
          elevator_hold = {1'b0, b[2]} - {1'b0, StickCenter};
          rudder_hold   = {1'b0, b[1]} - {1'b0, StickCenter};
          throttle_hold = b[0];
          new_flags = {b[5][FlagFlipBit], b[5][FlagReturnBit],
                       b[5][FlagHeadlessBit], b[5][FlagExpertBit]};
          change_hold = flag_hold ^ new_flags;
          flag_hold = new_flags;
          elapsed = '0;
          failsafe = 1'b0;
          r.status = StDataOk;
        end else begin
          r.status = StDataFail;
        end
        hop = hop + 2'd1;
      end
    end
    if (elapsed > {1'b0, fail_limit}) begin
      failsafe = 1'b1;
      aileron_hold = '0;
      elevator_hold = '0;
      rudder_hold = '0;
      throttle_hold = '0;
    end
    r.failsafe_active = failsafe;
    r.aileron         = aileron_hold;
    r.elevator        = elevator_hold;
    r.rudder          = rudder_hold;
    r.throttle        = throttle_hold;
    r.mode_flags      = flag_hold;
    r.flags_changed   = change_hold;
    r.radio_channel   = bound ? hop_table[8*hop +: 8] : BindChannel;
    r.bound_address   = addr;
    r.is_bound        = bound;
    return r;
  endfunction

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      hop_table     = HopTableRst;
      fail_limit    = FailLimitRst;
      bound         = 1'b0;
      addr          = AddrRst;
      hop           = '0;
      aileron_hold  = '0;
      elevator_hold = '0;
      rudder_hold   = '0;
      throttle_hold = '0;
      flag_hold     = '0;
      change_hold   = '0;
      elapsed       = '0;
      failsafe      = 1'b0;
      errors        = 0;
      awaited_words.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgHopTable:  hop_table = cfg_data_i[TableW-1:0];
          CfgFailLimit: fail_limit = cfg_data_i[LimitW-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_words.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual status %0d data %h",
                   $time, m_axis_tuser, m_axis_tdata);
          errors++;
        end else begin
          want = awaited_words.pop_front();
          got.status          = status_e'(m_axis_tuser);
          got.failsafe_active = m_axis_tdata[0];
          got.aileron         = m_axis_tdata[9:1];
          got.elevator        = m_axis_tdata[18:10];
          got.rudder          = m_axis_tdata[27:19];
          got.throttle        = m_axis_tdata[35:28];
          got.mode_flags      = m_axis_tdata[39:36];
          got.flags_changed   = m_axis_tdata[43:40];
          got.radio_channel   = m_axis_tdata[51:44];
          got.bound_address   = m_axis_tdata[75:52];
          got.is_bound        = m_axis_tdata[76];
          check_field("status", want.status, got.status);
          check_field("failsafe_active", want.failsafe_active, got.failsafe_active);
          check_field("aileron", int'(want.aileron), int'(got.aileron));
          check_field("elevator", int'(want.elevator), int'(got.elevator));
          check_field("rudder", int'(want.rudder), int'(got.rudder));
          check_field("throttle", want.throttle, got.throttle);
          check_field("mode_flags", want.mode_flags, got.mode_flags);
          check_field("flags_changed", want.flags_changed, got.flags_changed);
          check_field("radio_channel", want.radio_channel, got.radio_channel);
          check_field("bound_address", want.bound_address, got.bound_address);
          check_field("is_bound", want.is_bound, got.is_bound);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_words.push_back(decode_word(s_axis_tuser, s_axis_tdata[StepW-1:0],
                                            s_axis_tdata[InDataW-1:StepW]));
      end
      mismatches_o <= errors;
      pending_o    <= int'(awaited_words.size());
    end
  end

endmodule

/* tb/testbench.sv */
// Top of the testbench: clock, reset, stimulus, result sink, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;
  import rcprd_pkg::*;

  // Longest stretch without any accepted word before the run is declared hung.
  localparam int unsigned IdleLimit     = 2000;
  // Length of the deliberate result-side hold-off that backs up the pipeline.
  localparam int unsigned HoldOffCycles = 90;
  // Quiet cycles after the last result, comfortably above the pipeline latency.
  localparam int unsigned DrainCycles   = 8;
  // Unmapped register indexes; the block must ignore writes to them.
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  int unsigned         mismatches;
  int unsigned         pending;
  int unsigned         idle_cycles = 0;

  // Stimulus bookkeeping for the closing summary.
  int unsigned         word_count = 0;
  int unsigned         tick_count = 0;
  int unsigned         setting_count = 0;
  // When set, the sender offers words back to back with no gaps.
  logic                tx_burst = 1'b0;

  always #10 clk_i = ~clk_i;

  rc_packet_receiver_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  rcprd_checker word_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  // Appends the data checksum (8-bit sum of bytes 0 to 6) as byte 7. A corrupted
  // packet gets a checksum that is off by a random nonzero amount.
  function automatic logic [63:0] seal_data(input logic [55:0] body, input logic corrupt);
    logic [7:0] sum;
    sum = '0;
    for (int i = 0; i < 7; i++) sum += body[8*i +: 8];
    if (corrupt) sum += 8'($urandom_range(1, 255));
    return {sum, body};
  endfunction

  // Builds a bind packet: the address sits in bytes 4 to 6 and byte 7 holds their sum.
  function automatic logic [63:0] seal_bind(input logic [31:0] low, input logic [23:0] address);
    logic [7:0] sum;
    sum = address[7:0] + address[15:8] + address[23:16];
    return {sum, address, low};
  endfunction

  // Offers one word after a random gap (none in bursts), returns at the edge it is taken.
  // tdata carries the time step in the low 16 bits and payload bytes 0 to 7 above it.
  task automatic send_word(input logic func, input logic [15:0] step,
                           input logic [63:0] payload);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {payload, step};
    s_axis_tuser  <= func;
    do @(posedge clk_i); while (!s_axis_tready);
    word_count++;
    if (!func) tick_count++;
  endtask

  // Stops offering words and waits until every predicted result has been taken.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Leaves valid high; the caller lowers it once the last write is done.
  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Writes both registers while the block is idle, followed by writes to the two
  // unmapped indexes that must leave the settings untouched.
  task automatic configure(input logic [31:0] table_word, input logic [31:0] limit_word);
    drain();
    write_reg(CfgHopTable, table_word);
    write_reg(CfgFailLimit, limit_word);
    write_reg(CfgSpareA, $urandom);
    write_reg(CfgSpareB, $urandom);
    cfg_valid_i <= 1'b0;
    setting_count++;
  endtask

  // Mostly well-formed data packets with random content, the rest corrupted packets
  // and bare time ticks. Steps are mostly small so the link stays alive, with scattered
  // large steps that push the timer toward and past the limit.
  task automatic random_phase(input int unsigned count);
    logic [55:0] body;
    logic [15:0] step;
    int unsigned pick;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0:       step = '0;
        1:       step = '1;
        2, 3:    step = 16'($urandom);
        default: step = 16'($urandom_range(0, 2000));
      endcase
      body = 56'({$urandom, $urandom});
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_word(1'b1, step, seal_data(body, 1'b0));
      end else if (pick < 85) begin
        send_word(1'b1, step, seal_data(body, 1'b1));
      end else begin
        send_word(1'b0, step, {$urandom, $urandom});
      end
    end
  endtask

  // Result side: a random stall before each word, stretches with no stall, and
  // now and then a long hold-off while the sender keeps offering, which fills
  // the internal queue and must stall the input side.
  initial begin : result_sink
    int unsigned taken;
    int unsigned stall;
    logic        rx_burst;
    taken = 0;
    rx_burst = 1'b0;
    @(posedge clk_i);
    forever begin
      if (taken % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      if (taken % 400 == 150) begin
        stall = HoldOffCycles;
      end else if (rx_burst) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 13);
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      taken++;
    end
  end

  // Watchdog: any accepted word on any channel restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no word accepted for %0d cycles, %0d results outstanding",
               $time, idle_cycles, pending);
      $display("FAIL rc_packet_receiver_decoder");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset state seen through a bare time tick with all payload bits set, then a
    // payload carrying a valid bind sum that must be ignored because tuser is low.
    send_word(1'b0, 16'd0, '1);
    send_word(1'b0, 16'd1, seal_bind(32'h0, 24'h123456));
    // Bind attempt with a wrong sum; the timer keeps counting.
    send_word(1'b1, 16'hFFFF, {8'h00, 24'hFF_FFFF, 32'h0});

    configure($urandom, 32'd100000);
    // The timer runs in bind mode too and trips failsafe there.
    send_word(1'b0, 16'hFFFF, 64'h0);
    // Good bind; bind packets do not clear the timer, so failsafe stays set.
    send_word(1'b1, 16'd0, seal_bind($urandom, 24'h0180FF));
    // Stick extremes (aileron centered) with all four flags, then swapped extremes, no flags.
    send_word(1'b1, 16'd0, seal_data({8'h00, 8'hC5, 8'h00, 8'd50, 8'hFF, 8'h00, 8'hFF}, 1'b0));
    send_word(1'b1, 16'hFFFF,
              seal_data({8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00}, 1'b0));
    // A bad checksum keeps the held values but still steps the hop index.
    send_word(1'b1, 16'd100, seal_data(56'({$urandom, $urandom}), 1'b1));
    // Centered sticks with some flags set and the non-flag bits of byte 5 toggled.
    send_word(1'b1, 16'd0, seal_data({8'h80, 8'hBB, 8'h7F, 8'd50, 8'd50, 8'd50, 8'h80}, 1'b0));
    // Silence: failsafe zeroes the sticks but keeps the flags and change bits.
    send_word(1'b0, 16'hFFFF, {$urandom, $urandom});
    send_word(1'b0, 16'hFFFF, {$urandom, $urandom});
    send_word(1'b1, 16'd0, seal_data(56'({$urandom, $urandom}), 1'b1));
    send_word(1'b1, 16'd0, seal_data(56'({$urandom, $urandom}), 1'b0));

    // With a zero limit any nonzero elapsed time declares failsafe, while a good
    // packet clears the timer after its own step has been added.
    configure($urandom, {8'($urandom), 24'd0});
    send_word(1'b1, 16'd0, seal_data(56'({$urandom, $urandom}), 1'b0));
    send_word(1'b0, 16'd1, {$urandom, $urandom});
    send_word(1'b1, 16'd5, seal_data(56'({$urandom, $urandom}), 1'b0));
    send_word(1'b0, 16'd0, {$urandom, $urandom});

    configure($urandom, 32'($urandom_range(20000, 200000)));
    random_phase(150);

    configure(32'hFFFF_FFFF, {8'($urandom), 24'hFF_FFFF});
    random_phase(100);
    // Long blackout at the largest limit: failsafe, then the timer saturates.
    tx_burst = 1'b1;
    for (int n = 0; n < 520; n++) send_word(1'b0, 16'hFFFF, {$urandom, $urandom});
    send_word(1'b1, 16'hFFFF, seal_data(56'({$urandom, $urandom}), 1'b0));
    random_phase(30);

    configure(32'h0, 32'd1);
    random_phase(120);

    configure($urandom, {8'($urandom), 24'd0});
    random_phase(90);

    configure($urandom, 32'($urandom_range(1000, 70000)));
    random_phase(120);

    drain();
    $display("Run drove %0d words (%0d with payload, %0d time-only) over %0d register settings.",
             word_count, word_count - tick_count, tick_count, setting_count);
    $display("It covered bind, hop stepping, failsafe in both modes, limits 0, 1 and full scale.");
    if (mismatches == 0) begin
      $display("PASS rc_packet_receiver_decoder");
    end else begin
      $display("FAIL rc_packet_receiver_decoder");
    end
    $finish;
  end

endmodule

/* sim.f */
design/rcprd_pkg.sv
design/rcprd_front.sv
design/rcprd_queue.sv
design/rcprd_back.sv
design/rc_packet_receiver_decoder.sv
tb/rcprd_checker.sv
tb/testbench.sv
